@@ hw/rtl/cprc_pkg.sv @@
// Shared types and constants for the constraint pair rule checker.
package cprc_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] KIND_SELF      = 2'd0;
    localparam logic [1:0] KIND_DUPLICATE = 2'd1;
    localparam logic [1:0] KIND_ORPHAN    = 2'd2;
    localparam logic [1:0] KIND_FULL      = 2'd3;

    localparam int BM_SEL_BITS = 6;
    localparam int BM_WIDTH    = 1 << BM_SEL_BITS;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic add_rd;
        logic add_wr;
        logic chk_a;
        logic chk_b;
        logic probe;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic probe_done;
        logic emit_done;
    } t_stat;

endpackage

@@ hw/rtl/constraint_pair_rule_checker.sv @@
// An add item keeps busy high through its read and write states; a check item through its two
// check states, the probe state and the emit state, each violation leaving in the cycle after its emit.
// A new item is accepted only in idle; a check item is paced by the one-port hashed pair table probe.
// After reset and after every clear item a pass writes one row of the bitmap and of the pair
// table per cycle, with busy high.
// The receiver cannot stall: each result appears for exactly one cycle with o_valid.
module constraint_pair_rule_checker #(
    parameter int PAIR_CAPACITY = 1024,
    parameter int NODE_ID_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_first_node,
    input  logic [15:0] i_second_node,
    input  logic [31:0] i_distance_bits,
    output logic        o_valid,
    output logic [15:0] o_out_first_node,
    output logic [15:0] o_out_second_node,
    output logic [31:0] o_out_distance_bits,
    output logic [1:0]  o_kind,
    output logic        o_last
);

    cprc_pkg::t_cmd  cmd;
    cprc_pkg::t_stat stat;

    cprc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    cprc_dpath #(
        .PAIR_CAPACITY (PAIR_CAPACITY),
        .NODE_ID_BITS  (NODE_ID_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_op                (i_op),
        .i_first_node        (i_first_node),
        .i_second_node       (i_second_node),
        .i_distance_bits     (i_distance_bits),
        .o_valid             (o_valid),
        .o_out_first_node    (o_out_first_node),
        .o_out_second_node   (o_out_second_node),
        .o_out_distance_bits (o_out_distance_bits),
        .o_kind              (o_kind),
        .o_last              (o_last)
    );

endmodule

@@ hw/rtl/cprc_ctrl.sv @@
// Controller state machine that sequences clears, adds and checks.
module cprc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_op,
    input  cprc_pkg::t_stat  i_stat,
    output cprc_pkg::t_cmd   o_cmd,
    output logic             busy
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_ADD_RD = 8'b0000_0100,
        S_ADD_WR = 8'b0000_1000,
        S_CHK_A  = 8'b0001_0000,
        S_CHK_B  = 8'b0010_0000,
        S_PROBE  = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    case (i_op)
                        cprc_pkg::OP_CLEAR: n_state = S_CLEAR;
                        cprc_pkg::OP_ADD:   n_state = S_ADD_RD;
                        cprc_pkg::OP_CHECK: n_state = S_CHK_A;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD: begin
                o_cmd.add_rd = 1'b1;
                n_state      = S_ADD_WR;
            end
            S_ADD_WR: begin
                o_cmd.add_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_CHK_A: begin
                o_cmd.chk_a = 1'b1;
                n_state     = S_CHK_B;
            end
            S_CHK_B: begin
                o_cmd.chk_b = 1'b1;
                n_state     = S_PROBE;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_stat.probe_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ hw/rtl/cprc_dpath.sv @@
// Datapath with the known-node bitmap, the hashed pair table and the result registers.
module cprc_dpath #(
    parameter int PAIR_CAPACITY = 1024,
    parameter int NODE_ID_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cprc_pkg::t_cmd   i_cmd,
    output cprc_pkg::t_stat  o_stat,
    input  logic [1:0]       i_op,
    input  logic [15:0]      i_first_node,
    input  logic [15:0]      i_second_node,
    input  logic [31:0]      i_distance_bits,
    output logic             o_valid,
    output logic [15:0]      o_out_first_node,
    output logic [15:0]      o_out_second_node,
    output logic [31:0]      o_out_distance_bits,
    output logic [1:0]       o_kind,
    output logic             o_last
);

    localparam int BM_ROW_BITS = NODE_ID_BITS - cprc_pkg::BM_SEL_BITS;
    localparam int BM_ROWS     = 1 << BM_ROW_BITS;
    localparam int TBL_BITS    = $clog2(PAIR_CAPACITY);
    localparam int TBL_SIZE    = 1 << TBL_BITS;
    localparam int CNT_BITS    = $clog2(PAIR_CAPACITY + 1);
    localparam int CLR_BITS    = (BM_ROW_BITS > TBL_BITS) ? BM_ROW_BITS : TBL_BITS;

    logic [cprc_pkg::BM_WIDTH-1:0] bm_mem [BM_ROWS];
    logic [32:0]                   pr_mem [TBL_SIZE];

    logic [15:0]                   r_a;
    logic [15:0]                   r_b;
    logic [31:0]                   r_dist;
    logic                          r_self;
    logic                          r_known_a;
    logic                          r_known_b;
    logic                          r_slot;
    logic                          r_slot_full;
    logic [2:0]                    r_sent;
    logic [CLR_BITS-1:0]           r_clr_idx;
    logic [CNT_BITS-1:0]           r_count;
    logic [TBL_BITS-1:0]           r_probe_idx;
    logic [TBL_BITS-1:0]           r_probe_cnt;
    logic [cprc_pkg::BM_WIDTH-1:0] r_bm_rdata;
    logic [32:0]                   r_pr_rdata;
    logic                          r_o_valid;
    logic [1:0]                    r_o_kind;
    logic                          r_o_last;

    logic                          wide_a;
    logic                          wide_b;
    logic [BM_ROW_BITS-1:0]        row_a;
    logic [BM_ROW_BITS-1:0]        row_b;
    logic [15:0]                   hash_full;
    logic [TBL_BITS-1:0]           hash;
    logic [31:0]                   key;

    logic                          bm_we;
    logic [BM_ROW_BITS-1:0]        bm_waddr;
    logic [cprc_pkg::BM_WIDTH-1:0] bm_wdata;
    logic                          bm_re;
    logic [BM_ROW_BITS-1:0]        bm_raddr;

    logic                          pr_hit;
    logic                          pr_empty;
    logic                          pr_limit;
    logic                          room;
    logic                          insert;
    logic                          advance;
    logic                          pr_we;
    logic [TBL_BITS-1:0]           pr_waddr;
    logic [32:0]                   pr_wdata;
    logic                          pr_re;
    logic [TBL_BITS-1:0]           pr_raddr;

    logic                          orphan;
    logic [2:0]                    avail;
    logic [2:0]                    pick;
    logic [2:0]                    rest;
    logic [1:0]                    pick_kind;

    assign wide_a    = ((r_a >> NODE_ID_BITS) != 16'd0);
    assign wide_b    = ((r_b >> NODE_ID_BITS) != 16'd0);
    assign row_a     = r_a[NODE_ID_BITS-1:cprc_pkg::BM_SEL_BITS];
    assign row_b     = r_b[NODE_ID_BITS-1:cprc_pkg::BM_SEL_BITS];
    assign hash_full = r_b ^ {r_a[7:0], r_a[15:8]};
    assign hash      = hash_full[TBL_BITS-1:0];
    assign key       = {r_a, r_b};

    always_comb begin
        bm_we    = 1'b0;
        bm_waddr = row_a;
        bm_wdata = '0;
        if (i_cmd.clr_step) begin
            bm_we    = 1'b1;
            bm_waddr = r_clr_idx[BM_ROW_BITS-1:0];
        end else if (i_cmd.add_wr) begin
            bm_we    = !wide_a;
            bm_wdata = r_bm_rdata
                     | ({{(cprc_pkg::BM_WIDTH-1){1'b0}}, 1'b1}
                        << r_a[cprc_pkg::BM_SEL_BITS-1:0]);
        end
        bm_re    = i_cmd.add_rd || i_cmd.chk_a || i_cmd.chk_b;
        bm_raddr = i_cmd.chk_b ? row_b : row_a;
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re) begin
            r_bm_rdata <= bm_mem[bm_raddr];
        end
    end

    assign pr_hit   = r_pr_rdata[32] && (r_pr_rdata[31:0] == key);
    assign pr_empty = !r_pr_rdata[32];
    assign pr_limit = (r_probe_cnt == TBL_BITS'(TBL_SIZE - 1));
    assign room     = (r_count < CNT_BITS'(PAIR_CAPACITY));
    assign insert   = i_cmd.probe && !pr_hit && pr_empty && room;
    assign advance  = i_cmd.probe && !pr_hit && !pr_empty && !pr_limit;

    always_comb begin
        pr_we    = 1'b0;
        pr_waddr = r_probe_idx;
        pr_wdata = {1'b1, key};
        if (i_cmd.clr_step) begin
            pr_we    = 1'b1;
            pr_waddr = r_clr_idx[TBL_BITS-1:0];
            pr_wdata = '0;
        end else if (insert) begin
            pr_we = 1'b1;
        end
        pr_re    = i_cmd.chk_a || advance;
        pr_raddr = i_cmd.chk_a ? hash : r_probe_idx + TBL_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (pr_we) begin
            pr_mem[pr_waddr] <= pr_wdata;
        end
        if (pr_re) begin
            r_pr_rdata <= pr_mem[pr_raddr];
        end
    end

    assign orphan    = !r_known_a || !r_known_b;
    assign avail     = {orphan, r_slot, r_self} & ~r_sent;
    assign pick      = avail & (~avail + 3'd1);
    assign rest      = avail & ~pick;
    assign pick_kind = pick[0] ? cprc_pkg::KIND_SELF
                     : pick[1] ? (r_slot_full ? cprc_pkg::KIND_FULL
                                              : cprc_pkg::KIND_DUPLICATE)
                     : cprc_pkg::KIND_ORPHAN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_count   <= '0;
            r_sent    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit && (avail != 3'd0);
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + CLR_BITS'(1);
                r_count   <= '0;
            end else if (insert) begin
                r_count <= r_count + CNT_BITS'(1);
            end
            if (i_cmd.accept) begin
                r_sent <= '0;
            end else if (i_cmd.emit) begin
                r_sent <= r_sent | pick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a    <= i_first_node;
            r_b    <= i_second_node;
            r_dist <= i_distance_bits;
            r_self <= (i_op == cprc_pkg::OP_CHECK) && (i_first_node == i_second_node);
        end
        if (i_cmd.chk_a) begin
            r_probe_idx <= hash;
            r_probe_cnt <= '0;
            r_slot      <= 1'b0;
            r_slot_full <= 1'b0;
        end else if (advance) begin
            r_probe_idx <= r_probe_idx + TBL_BITS'(1);
            r_probe_cnt <= r_probe_cnt + TBL_BITS'(1);
        end else if (i_cmd.probe) begin
            r_slot      <= pr_hit || !room;
            r_slot_full <= !pr_hit;
        end
        if (i_cmd.chk_b) begin
            r_known_a <= r_bm_rdata[r_a[cprc_pkg::BM_SEL_BITS-1:0]] && !wide_a;
        end
        if (i_cmd.probe) begin
            r_known_b <= r_bm_rdata[r_b[cprc_pkg::BM_SEL_BITS-1:0]] && !wide_b;
        end
        if (i_cmd.emit) begin
            r_o_kind <= pick_kind;
            r_o_last <= (rest == 3'd0);
        end
    end

    assign o_stat.clr_last   = &r_clr_idx;
    assign o_stat.probe_done = pr_hit || pr_empty || pr_limit;
    assign o_stat.emit_done  = (rest == 3'd0);

    assign o_valid             = r_o_valid;
    assign o_out_first_node    = r_a;
    assign o_out_second_node   = r_b;
    assign o_out_distance_bits = r_dist;
    assign o_kind              = r_o_kind;
    assign o_last              = r_o_last;

endmodule
